// File: rtl/thk_pkg.sv
// Shared types, constants and helper functions of the kinetic tensor accumulator.
package thk_pkg;

    // Default fixed-point fraction width and queue depth.
    localparam int unsigned THK_FRAC_BITS   = 16;
    localparam int unsigned THK_QUEUE_DEPTH = 4;

    // Tensor layout: xx yy zz xy xz yz, and the result slots with the temperature first.
    localparam int unsigned AXIS_N   = 3;
    localparam int unsigned TENSOR_N = 6;
    localparam int unsigned RES_N    = TENSOR_N + 1;
    localparam int unsigned RES_TEMP = 0;

    // Velocity axes that form each tensor component.
    localparam int unsigned PAIR_A [TENSOR_N] = '{0, 1, 2, 0, 0, 1};
    localparam int unsigned PAIR_B [TENSOR_N] = '{0, 1, 2, 1, 2, 2};

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_X        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_FACTOR   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_FACTOR = 8'd4;

    // Accumulator word and its saturation limits.
    typedef logic signed [63:0] acc_t;
    localparam acc_t SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam acc_t SUM_MIN = 64'sh8000_0000_0000_0000;

    // One atom after the center-of-mass velocity has been removed.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [31:0]        mass;
        logic               grp;
        logic               last;
    } q_entry_t;

    // Queue write side and read side.
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_wr_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_rd_t;

    // Final sums handed from the accumulator to the finishing sequencer.
    typedef struct packed {
        logic                     valid;
        acc_t [TENSOR_N-1:0]      sums;
    } acc_out_t;

    // Scale factors used by the finishing sequencer.
    typedef struct packed {
        logic [31:0] temp_factor;
        logic [31:0] energy_factor;
    } cfg_factors_t;

    // Signed 64-bit addition that saturates at both ends of the range.
    function automatic acc_t sat_add64(input acc_t a, input acc_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? SUM_MIN : SUM_MAX;
        end
        return s[63:0];
    endfunction

endpackage

// File: rtl/thk_if.sv
// Channel interfaces: atom items, result items and configuration writes.
interface thk_item_if import thk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        atom_mass;
    logic               in_group;
    logic               last_atom;

    modport source (output valid, vel_x, vel_y, vel_z, atom_mass, in_group, last_atom,
                    input ready);
    modport sink   (input valid, vel_x, vel_y, vel_z, atom_mass, in_group, last_atom,
                    output ready);
endinterface

interface thk_result_if import thk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [62:0]        temperature;
    logic [62:0]        ke_xx;
    logic [62:0]        ke_yy;
    logic [62:0]        ke_zz;
    logic signed [63:0] ke_xy;
    logic signed [63:0] ke_xz;
    logic signed [63:0] ke_yz;

    modport source (output valid, temperature, ke_xx, ke_yy, ke_zz, ke_xy, ke_xz, ke_yz,
                    input ready);
    modport sink   (input valid, temperature, ke_xx, ke_yy, ke_zz, ke_xy, ke_xz, ke_yz,
                    output ready);
endinterface

interface thk_cfg_if import thk_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/thk_front.sv
// Front end: configuration registers, atom intake and thermal velocity formation.
module thk_front import thk_pkg::*; #(
    parameter int unsigned FRAC_BITS = THK_FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    thk_cfg_if.sink       cfg,
    thk_item_if.sink      item,
    output q_wr_t         wr,
    input  logic          q_full,
    output cfg_factors_t  factors
);

    localparam logic [31:0] ENERGY_ONE = 32'(1) << FRAC_BITS;

    logic [31:0] bias_x_reg, bias_x_next;
    logic [31:0] bias_y_reg, bias_y_next;
    logic [31:0] bias_z_reg, bias_z_next;
    logic [31:0] temp_factor_reg, temp_factor_next;
    logic [31:0] energy_factor_reg, energy_factor_next;

    // Register writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        bias_x_next        = bias_x_reg;
        bias_y_next        = bias_y_reg;
        bias_z_next        = bias_z_reg;
        temp_factor_next   = temp_factor_reg;
        energy_factor_next = energy_factor_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_BIAS_X:        bias_x_next        = cfg.data;
                REG_BIAS_Y:        bias_y_next        = cfg.data;
                REG_BIAS_Z:        bias_z_next        = cfg.data;
                REG_TEMP_FACTOR:   temp_factor_next   = cfg.data;
                REG_ENERGY_FACTOR: energy_factor_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_x_reg        <= '0;
            bias_y_reg        <= '0;
            bias_z_reg        <= '0;
            temp_factor_reg   <= '0;
            energy_factor_reg <= ENERGY_ONE;
        end
        else
        begin
            bias_x_reg        <= bias_x_next;
            bias_y_reg        <= bias_y_next;
            bias_z_reg        <= bias_z_next;
            temp_factor_reg   <= temp_factor_next;
            energy_factor_reg <= energy_factor_next;
        end
    end

    assign factors.temp_factor   = temp_factor_reg;
    assign factors.energy_factor = energy_factor_reg;

    // A transaction is taken whenever the queue has room.
    assign item.ready = !q_full;
    assign wr.valid   = item.valid && !q_full;

    // Thermal velocity is exact in 33 bits.
    assign wr.entry.dx   = {item.vel_x[31], item.vel_x} - {bias_x_reg[31], bias_x_reg};
    assign wr.entry.dy   = {item.vel_y[31], item.vel_y} - {bias_y_reg[31], bias_y_reg};
    assign wr.entry.dz   = {item.vel_z[31], item.vel_z} - {bias_z_reg[31], bias_z_reg};
    assign wr.entry.mass = item.atom_mass;
    assign wr.entry.grp  = item.in_group;
    assign wr.entry.last = item.last_atom;

endmodule

// File: rtl/thk_queue.sv
// Small FIFO that decouples the front end from the accumulation pipeline.
module thk_queue import thk_pkg::*; #(
    parameter int unsigned DEPTH = THK_QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t wr,
    output logic  full,
    output q_rd_t rd,
    input  logic  pop
);

    localparam int unsigned PTRW = $clog2(DEPTH);
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    q_entry_t        mem_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.entry = mem_reg[rd_ptr_reg];

    assign do_push = wr.valid && !full;
    assign do_pop  = pop && rd.valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr.entry;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNTW'(DEPTH)) && !(do_pop && (count_reg == '0)))
        else $error("queue fill count out of range");
`endif

endmodule

// File: rtl/thk_accum.sv
// Product pipeline and saturating tensor accumulators.
module thk_accum import thk_pkg::*; #(
    parameter int unsigned FRAC_BITS = THK_FRAC_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  q_rd_t    head,
    output logic     pop,
    output acc_out_t acc,
    input  logic     fin_ready
);

    // Widths of the velocity product, the partial mass products and the rounded magnitude.
    localparam int unsigned VW = 64 - FRAC_BITS;
    localparam int unsigned VL = (VW + 1) / 2;
    localparam int unsigned VH = VW - VL;
    localparam int unsigned PW = VW + 32;
    localparam int unsigned MW = PW - FRAC_BITS + 1;
    localparam int unsigned CW = (MW > 64) ? MW : 64;

    logic advance;
    logic fire;

    logic signed [32:0] d_in [AXIS_N];

    // Stage 1: magnitudes and signs of the thermal velocity.
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] mag1_reg [AXIS_N], mag1_next [AXIS_N];
    logic        sgn1_reg [AXIS_N], sgn1_next [AXIS_N];
    logic [31:0] mass1_reg;
    logic        grp1_reg, last1_reg;

    // Stage 2: exact velocity products.
    logic        s2_valid_reg;
    logic [63:0] prod2_reg [TENSOR_N], prod2_next [TENSOR_N];
    logic        neg2_reg [TENSOR_N], neg2_next [TENSOR_N];
    logic [31:0] mass2_reg;
    logic        grp2_reg, last2_reg;

    // Stage 3: velocity products shifted with floor rounding.
    logic          s3_valid_reg;
    logic [VW-1:0] vv3_reg [TENSOR_N], vv3_next [TENSOR_N];
    logic          neg3_reg [TENSOR_N];
    logic [31:0]   mass3_reg;
    logic          grp3_reg, last3_reg;

    // Stage 4: partial products with the mass.
    logic             s4_valid_reg;
    logic [VL+31:0]   pl4_reg [TENSOR_N], pl4_next [TENSOR_N];
    logic [VH+31:0]   ph4_reg [TENSOR_N], ph4_next [TENSOR_N];
    logic             neg4_reg [TENSOR_N];
    logic             grp4_reg, last4_reg;

    // Stage 5: full mass product.
    logic          s5_valid_reg;
    logic [PW-1:0] full5_reg [TENSOR_N], full5_next [TENSOR_N];
    logic          neg5_reg [TENSOR_N];
    logic          grp5_reg, last5_reg;

    // Stage 6: shifted magnitude, rounded toward minus infinity.
    logic          s6_valid_reg;
    logic [MW-1:0] m6_reg [TENSOR_N], m6_next [TENSOR_N];
    logic          neg6_reg [TENSOR_N];
    logic          grp6_reg, last6_reg;

    // Stage 7: saturated signed contribution.
    logic s7_valid_reg;
    acc_t term7_reg [TENSOR_N], term7_next [TENSOR_N];
    logic grp7_reg, last7_reg;

    // Accumulators.
    acc_t sums_reg [TENSOR_N], sums_next [TENSOR_N];
    acc_t add_sum [TENSOR_N];

    assign d_in[0] = head.entry.dx;
    assign d_in[1] = head.entry.dy;
    assign d_in[2] = head.entry.dz;

    // A last atom at the end of the pipeline waits until the finisher is free.
    assign advance = !(s7_valid_reg && last7_reg) || fin_ready;
    assign fire    = s7_valid_reg && advance;
    assign pop     = head.valid && advance;

    // Per-lane datapath of every stage.
    always_comb
    begin
        logic [CW-1:0] m_ext;
        logic [63:0]   lim;
        logic [63:0]   clamp;
        s1_valid_next = head.valid;
        for (int j = 0; j < AXIS_N; j++)
        begin
            sgn1_next[j] = d_in[j][32];
            mag1_next[j] = d_in[j][32] ? 32'(-d_in[j]) : d_in[j][31:0];
        end
        for (int i = 0; i < TENSOR_N; i++)
        begin
            prod2_next[i] = mag1_reg[PAIR_A[i]] * mag1_reg[PAIR_B[i]];
            neg2_next[i]  = sgn1_reg[PAIR_A[i]] ^ sgn1_reg[PAIR_B[i]];

            vv3_next[i] = VW'(prod2_reg[i][63:FRAC_BITS])
                        + VW'(neg2_reg[i] && (prod2_reg[i][FRAC_BITS-1:0] != '0));

            pl4_next[i] = vv3_reg[i][VL-1:0] * mass3_reg;
            ph4_next[i] = vv3_reg[i][VW-1:VL] * mass3_reg;

            full5_next[i] = PW'(pl4_reg[i]) + (PW'(ph4_reg[i]) << VL);

            m6_next[i] = MW'(full5_reg[i][PW-1:FRAC_BITS])
                       + MW'(neg5_reg[i] && (full5_reg[i][FRAC_BITS-1:0] != '0));

            m_ext = CW'(m6_reg[i]);
            lim   = neg6_reg[i] ? SUM_MIN : SUM_MAX;
            clamp = (m_ext > CW'(lim)) ? lim : m_ext[63:0];
            term7_next[i] = neg6_reg[i] ? acc_t'(-clamp) : acc_t'(clamp);
        end
    end

    // Accumulation; a last atom hands its totals over and restarts from zero.
    always_comb
    begin
        for (int i = 0; i < TENSOR_N; i++)
        begin
            add_sum[i]  = grp7_reg ? sat_add64(sums_reg[i], term7_reg[i]) : sums_reg[i];
            sums_next[i] = sums_reg[i];
            if (fire)
            begin
                sums_next[i] = last7_reg ? '0 : add_sum[i];
            end
            acc.sums[i] = add_sum[i];
        end
        acc.valid = s7_valid_reg && last7_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            for (int i = 0; i < TENSOR_N; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= s1_valid_next;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                s6_valid_reg <= s5_valid_reg;
                s7_valid_reg <= s6_valid_reg;
            end
            for (int i = 0; i < TENSOR_N; i++)
            begin
                sums_reg[i] <= sums_next[i];
            end
        end
    end

    // Pipeline payload moves in lockstep with the valid bits.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 0; j < AXIS_N; j++)
            begin
                mag1_reg[j] <= mag1_next[j];
                sgn1_reg[j] <= sgn1_next[j];
            end
            mass1_reg <= head.entry.mass;
            grp1_reg  <= head.entry.grp;
            last1_reg <= head.entry.last;

            mass2_reg <= mass1_reg;
            grp2_reg  <= grp1_reg;
            last2_reg <= last1_reg;
            mass3_reg <= mass2_reg;
            grp3_reg  <= grp2_reg;
            last3_reg <= last2_reg;
            grp4_reg  <= grp3_reg;
            last4_reg <= last3_reg;
            grp5_reg  <= grp4_reg;
            last5_reg <= last4_reg;
            grp6_reg  <= grp5_reg;
            last6_reg <= last5_reg;
            grp7_reg  <= grp6_reg;
            last7_reg <= last6_reg;

            for (int i = 0; i < TENSOR_N; i++)
            begin
                prod2_reg[i] <= prod2_next[i];
                neg2_reg[i]  <= neg2_next[i];
                vv3_reg[i]   <= vv3_next[i];
                neg3_reg[i]  <= neg2_reg[i];
                pl4_reg[i]   <= pl4_next[i];
                ph4_reg[i]   <= ph4_next[i];
                neg4_reg[i]  <= neg3_reg[i];
                full5_reg[i] <= full5_next[i];
                neg5_reg[i]  <= neg4_reg[i];
                m6_reg[i]    <= m6_next[i];
                neg6_reg[i]  <= neg5_reg[i];
                term7_reg[i] <= term7_next[i];
            end
        end
    end

`ifndef SYNTH
    a_diag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !sums_reg[0][63] && !sums_reg[1][63] && !sums_reg[2][63])
        else $error("diagonal accumulator went negative");

    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s7_valid_reg && last7_reg && !fin_ready) |=> (s7_valid_reg && last7_reg))
        else $error("last atom dropped while the finisher was busy");
`endif

endmodule

// File: rtl/thk_finish.sv
// Finishing sequencer: trace, scaling of the seven results and the output register.
module thk_finish import thk_pkg::*; #(
    parameter int unsigned FRAC_BITS = THK_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  acc_out_t     acc,
    output logic         fin_ready,
    input  cfg_factors_t factors,
    thk_result_if.source result
);

    localparam int unsigned KW  = $clog2(RES_N);
    localparam int unsigned FMW = 97 - FRAC_BITS;
    localparam int unsigned FCW = (FMW > 64) ? FMW : 64;

    typedef enum logic [8:0] {
        FIN_IDLE = 9'b0_0000_0001,
        FIN_TR1  = 9'b0_0000_0010,
        FIN_TR2  = 9'b0_0000_0100,
        FIN_ABS  = 9'b0_0000_1000,
        FIN_MUL  = 9'b0_0001_0000,
        FIN_COMB = 9'b0_0010_0000,
        FIN_RND  = 9'b0_0100_0000,
        FIN_SAT  = 9'b0_1000_0000,
        FIN_OUT  = 9'b1_0000_0000
    } fin_state_t;

    fin_state_t     state_reg, state_next;
    logic [KW-1:0]  k_reg, k_next;
    acc_t           opnd_reg [RES_N], opnd_next [RES_N];
    acc_t           res_reg [RES_N], res_next [RES_N];
    acc_t           out_reg [RES_N], out_next [RES_N];
    logic           out_valid_reg, out_valid_next;
    logic [63:0]    mag_reg, mag_next;
    logic           neg_reg, neg_next;
    logic [63:0]    pl_reg, pl_next;
    logic [63:0]    ph_reg, ph_next;
    logic [95:0]    full_reg, full_next;
    logic [FMW-1:0] m_reg, m_next;

    assign fin_ready = (state_reg == FIN_IDLE);

    always_comb
    begin
        acc_t          op;
        logic [31:0]   factor;
        logic [FCW-1:0] m_ext;
        logic [63:0]   lim;
        logic [63:0]   clamp;

        state_next     = state_reg;
        k_next         = k_reg;
        opnd_next      = opnd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        pl_next        = pl_reg;
        ph_next        = ph_reg;
        full_next      = full_reg;
        m_next         = m_reg;

        op     = opnd_reg[k_reg];
        factor = (k_reg == KW'(RES_TEMP)) ? factors.temp_factor : factors.energy_factor;
        m_ext  = FCW'(m_reg);
        lim    = neg_reg ? SUM_MIN : SUM_MAX;
        clamp  = (m_ext > FCW'(lim)) ? lim : m_ext[63:0];

        // The waiting result leaves when the sink takes it.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            FIN_IDLE:
            begin
                if (acc.valid)
                begin
                    for (int i = 0; i < TENSOR_N; i++)
                    begin
                        opnd_next[i + 1] = acc.sums[i];
                    end
                    k_next     = KW'(RES_TEMP);
                    state_next = FIN_TR1;
                end
            end
            // Trace in two saturating adds.
            FIN_TR1:
            begin
                opnd_next[RES_TEMP] = sat_add64(opnd_reg[1], opnd_reg[2]);
                state_next          = FIN_TR2;
            end
            FIN_TR2:
            begin
                opnd_next[RES_TEMP] = sat_add64(opnd_reg[RES_TEMP], opnd_reg[3]);
                state_next          = FIN_ABS;
            end
            // Sign-magnitude form of the current operand.
            FIN_ABS:
            begin
                neg_next   = op[63];
                mag_next   = op[63] ? 64'(-op) : 64'(op);
                state_next = FIN_MUL;
            end
            // Two 32-by-32 partial products with the scale factor.
            FIN_MUL:
            begin
                pl_next    = mag_reg[31:0] * factor;
                ph_next    = mag_reg[63:32] * factor;
                state_next = FIN_COMB;
            end
            FIN_COMB:
            begin
                full_next  = 96'(pl_reg) + (96'(ph_reg) << 32);
                state_next = FIN_RND;
            end
            // Shift out the fraction, rounding negative values toward minus infinity.
            FIN_RND:
            begin
                m_next = FMW'(full_reg[95:FRAC_BITS])
                       + FMW'(neg_reg && (full_reg[FRAC_BITS-1:0] != '0));
                state_next = FIN_SAT;
            end
            FIN_SAT:
            begin
                res_next[k_reg] = neg_reg ? acc_t'(-clamp) : acc_t'(clamp);
                if (k_reg == KW'(RES_N - 1))
                begin
                    state_next = FIN_OUT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = FIN_ABS;
                end
            end
            // Load the output register once it is free.
            FIN_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = FIN_IDLE;
                end
            end
            default:
            begin
                state_next = FIN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FIN_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        pl_reg   <= pl_next;
        ph_reg   <= ph_next;
        full_reg <= full_next;
        m_reg    <= m_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.temperature = out_reg[RES_TEMP][62:0];
    assign result.ke_xx       = out_reg[1][62:0];
    assign result.ke_yy       = out_reg[2][62:0];
    assign result.ke_zz       = out_reg[3][62:0];
    assign result.ke_xy       = out_reg[4];
    assign result.ke_xz       = out_reg[5];
    assign result.ke_yz       = out_reg[6];

`ifndef SYNTH
    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FIN_IDLE && !acc.valid) |=> (state_reg == FIN_IDLE))
        else $error("finisher left idle without a set of sums");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == FIN_OUT))
        else $error("result appeared without a finished sequence");
`endif

endmodule

// File: rtl/thermal_kinetic_tensor_accumulator_top.sv
// Top level of the center-of-mass corrected kinetic temperature and tensor accumulator.
//
// Each transaction on the item channel carries one atom. The front end subtracts the
// configured center-of-mass velocity and pushes the atom into a queue of QUEUE_DEPTH
// entries; a seven-stage product pipeline pulls one atom per cycle from the queue, so
// atoms are accepted at one per cycle unless that pipeline stalls. On an atom marked
// last the six sums are handed to a finishing sequencer that forms the trace in two
// saturating adds and then, over one shared pair of 32-by-32 multipliers, takes each of
// the seven results through sign-magnitude form, partial products, their sum, rounding
// and saturation before it loads the output register. While it works, atoms of the next
// set keep flowing; only a second last atom that reaches the end of the pipeline waits
// for it. The result of a set waits in an output register without blocking intake.
// Values are fixed point with FRAC_BITS fraction bits; products are truncated toward
// minus infinity and all sums saturate to the signed 64-bit range. Configuration writes
// are taken in any cycle but are meant for times when no set is in progress.
module thermal_kinetic_tensor_accumulator_top import thk_pkg::*; #(
    parameter int unsigned FRAC_BITS   = THK_FRAC_BITS,
    parameter int unsigned QUEUE_DEPTH = THK_QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    thk_cfg_if.sink      cfg,
    thk_item_if.sink     item,
    thk_result_if.source result
);

    q_wr_t        q_wr;
    q_rd_t        q_rd;
    logic         q_full;
    logic         q_pop;
    acc_out_t     acc;
    logic         fin_ready;
    cfg_factors_t factors;

    thk_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item),
        .wr      (q_wr),
        .q_full  (q_full),
        .factors (factors)
    );

    thk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .rd    (q_rd),
        .pop   (q_pop)
    );

    thk_accum #(
        .FRAC_BITS (FRAC_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_rd),
        .pop       (q_pop),
        .acc       (acc),
        .fin_ready (fin_ready)
    );

    thk_finish #(
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .fin_ready (fin_ready),
        .factors   (factors),
        .result    (result)
    );

endmodule
